### src/htbd_pkg.sv
// Package for the code tree bit decoder: item structs, command and status
// structs, shared codes and field widths. No dependencies.

package htbd_pkg;

	// Field widths of the items
	localparam int SYM_W      = 8;
	localparam int CODE_W     = 32;
	localparam int CODE_LEN_W = 6;

	// Width that holds any clipped code length (up to 63) and bit position
	localparam int CLIP_W = 7;
	localparam int POS_W  = $clog2(CODE_W);

	// Defaults for the top-level parameters
	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 32;

	// Request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DECODE = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [SYM_W-1:0]      symbol_in;
		logic [CODE_W-1:0]     code_word;
		logic [CODE_LEN_W-1:0] code_length;
		logic                  code_bit;
	} req_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol_out;
		logic             symbol_valid;
		logic             error_flag;
	} rsp_t;

	// Node table read address select
	typedef enum logic [1:0] {
		RD_STEP = 2'd0,
		RD_CUR  = 2'd1,
		RD_NODE = 2'd2
	} rd_sel_t;

	// Result kinds that close an item
	typedef enum logic [2:0] {
		RES_NONE     = 3'd0,
		RES_DEC_MISS = 3'd1,
		RES_DEC_EVAL = 3'd2,
		RES_INS_OK   = 3'd3,
		RES_INS_FULL = 3'd4
	} res_t;

	typedef struct packed {
		logic    accept;
		logic    use_in_bit;
		rd_sel_t rd_sel;
		logic    step_go;
		logic    cache_load;
		logic    ins_step;
		res_t    res;
	} cmd_t;

	typedef struct packed {
		logic cur_known;
		logic step_miss;
		logic ins_done;
		logic ins_desc;
		logic ins_full;
	} stat_t;

endpackage

### src/htbd_ctrl.sv
// Controller of the code tree bit decoder: handshake, item sequencing and
// the output valid flag. Depends on htbd_pkg.

module htbd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_type,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  htbd_pkg::stat_t stat,
	output htbd_pkg::cmd_t  cmd
);
	import htbd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DEC_LOAD = 6'b000010,
		ST_DEC_STEP = 6'b000100,
		ST_DEC_EVAL = 6'b001000,
		ST_INS_STEP = 6'b010000,
		ST_INS_READ = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;
	logic   accept;

	// Take an item only in idle with the output slot free or draining
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == ST_IDLE) && out_free);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d        = state_q;
		cmd.accept     = accept;
		cmd.use_in_bit = (state_q == ST_IDLE);
		cmd.rd_sel     = RD_STEP;
		cmd.step_go    = 1'b0;
		cmd.cache_load = 1'b0;
		cmd.ins_step   = 1'b0;
		cmd.res        = RES_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_DECODE) begin
						if (stat.cur_known) begin
							if (stat.step_miss) begin
								cmd.res = RES_DEC_MISS;
							end else begin
								cmd.step_go = 1'b1;
								state_d     = ST_DEC_EVAL;
							end
						end else begin
							cmd.rd_sel = RD_CUR;
							state_d    = ST_DEC_LOAD;
						end
					end else begin
						state_d = ST_INS_STEP;
					end
				end
			end
			ST_DEC_LOAD: begin
				cmd.cache_load = 1'b1;
				state_d        = ST_DEC_STEP;
			end
			ST_DEC_STEP: begin
				if (stat.step_miss) begin
					cmd.res = RES_DEC_MISS;
					state_d = ST_IDLE;
				end else begin
					cmd.step_go = 1'b1;
					state_d     = ST_DEC_EVAL;
				end
			end
			ST_DEC_EVAL: begin
				cmd.res = RES_DEC_EVAL;
				state_d = ST_IDLE;
			end
			ST_INS_STEP: begin
				cmd.ins_step = 1'b1;
				if (stat.ins_done) begin
					cmd.res = RES_INS_OK;
					state_d = ST_IDLE;
				end else if (stat.ins_desc) begin
					state_d = ST_INS_READ;
				end else if (stat.ins_full) begin
					cmd.res = RES_INS_FULL;
					state_d = ST_IDLE;
				end
			end
			ST_INS_READ: begin
				cmd.rd_sel = RD_NODE;
				state_d    = ST_INS_STEP;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state; hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res != RES_NONE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/htbd_dpath.sv
// Datapath of the code tree bit decoder: node tables, root and current node
// registers, insert walk and output register. Depends on htbd_pkg.

module htbd_dpath #(
	parameter int NODE_COUNT   = htbd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  htbd_pkg::req_t  req,
	input  htbd_pkg::cmd_t  cmd,
	output htbd_pkg::stat_t stat,
	output htbd_pkg::rsp_t  rsp
);
	import htbd_pkg::*;

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int CNT_W  = $clog2(NODE_COUNT + 1);
	localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
	localparam logic [CNT_W-1:0]  NODE_LIMIT = CNT_W'(NODE_COUNT);
	localparam logic [CLIP_W-1:0] LEN_MAX    = CLIP_W'(MAX_CODE_LEN);

	// Node tables; entries are written before their read data is used
	logic [NODE_W-1:0] left_mem  [NODE_COUNT];
	logic [NODE_W-1:0] right_mem [NODE_COUNT];
	logic [SYM_W-1:0]  sym_mem   [NODE_COUNT];

	logic [NODE_W-1:0] rd_left_q, rd_right_q;
	logic [SYM_W-1:0]  rd_sym_q;

	// Root children live in flops so reset clears them at once
	logic [NODE_W-1:0] root_left_q, root_right_q;

	// Decode walk state
	logic [NODE_W-1:0] cur_q, next_q;
	logic [NODE_W-1:0] cache_left_q, cache_right_q;
	logic              cache_ok_q;
	logic              bit_q;

	// Insert walk state
	logic [SYM_W-1:0]  sym_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  remain_q;
	logic [NODE_W-1:0] node_q;
	logic              fresh_q;
	logic [CNT_W-1:0]  count_q;

	rsp_t out_q;

	logic              step_bit, cur_root;
	logic [NODE_W-1:0] step_left, step_right, step_next;
	logic              node_root;
	logic [NODE_W-1:0] ent_left, ent_right, ins_slot, fresh_idx;
	logic [CLIP_W-1:0] pos_c, len_ext, len_clip;
	logic              ins_bit, ins_done, ins_desc, ins_full, alloc, seal;
	logic [NODE_W-1:0] new_left, new_right;
	logic              wr_en;
	logic [NODE_W-1:0] wr_left, wr_right, rd_addr;
	logic              rd_leaf;

	// Decode step: pick the child of the current node
	assign step_bit   = cmd.use_in_bit ? req.code_bit : bit_q;
	assign cur_root   = (cur_q == '0);
	assign step_left  = cur_root ? root_left_q : cache_left_q;
	assign step_right = cur_root ? root_right_q : cache_right_q;
	assign step_next  = step_bit ? step_right : step_left;
	assign rd_leaf    = (rd_left_q == '0) && (rd_right_q == '0);

	// Insert step: children of the walk node, fresh nodes have none
	assign node_root = (node_q == '0);
	assign ent_left  = node_root ? root_left_q : (fresh_q ? '0 : rd_left_q);
	assign ent_right = node_root ? root_right_q : (fresh_q ? '0 : rd_right_q);
	assign pos_c     = CLIP_W'(remain_q) - CLIP_W'(1);
	assign ins_bit   = (pos_c < CLIP_W'(CODE_W)) ? code_q[pos_c[POS_W-1:0]] : 1'b0;
	assign ins_slot  = ins_bit ? ent_right : ent_left;
	assign ins_done  = (remain_q == '0);
	assign ins_desc  = (ins_slot != '0);
	assign ins_full  = (count_q >= NODE_LIMIT);
	assign fresh_idx = count_q[NODE_W-1:0];
	assign alloc     = cmd.ins_step && !ins_done && !ins_desc && !ins_full;
	assign seal      = cmd.ins_step && fresh_q && (ins_done || ins_full);
	assign new_left  = ins_bit ? ent_left : fresh_idx;
	assign new_right = ins_bit ? fresh_idx : ent_right;

	// Table write: link a new child, or clear the last fresh node's children
	assign wr_en    = seal || (alloc && !node_root);
	assign wr_left  = alloc ? new_left : '0;
	assign wr_right = alloc ? new_right : '0;

	// Clip the code length to the longest supported code
	assign len_ext  = CLIP_W'(req.code_length);
	assign len_clip = (len_ext > LEN_MAX) ? LEN_MAX : len_ext;

	// Table read address
	always_comb begin
		unique case (cmd.rd_sel)
			RD_STEP: rd_addr = step_next;
			RD_CUR:  rd_addr = cur_q;
			RD_NODE: rd_addr = node_q;
			default: rd_addr = step_next;
		endcase
	end

	// Node tables with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_mem[node_q]  <= wr_left;
			right_mem[node_q] <= wr_right;
		end
		if (alloc) begin
			sym_mem[fresh_idx] <= sym_q;
		end
		rd_left_q  <= left_mem[rd_addr];
		rd_right_q <= right_mem[rd_addr];
		rd_sym_q   <= sym_mem[rd_addr];
	end

	// Capture item payload and the decode target
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q  <= req.symbol_in;
			code_q <= req.code_word;
			bit_q  <= req.code_bit;
		end
		if (cmd.step_go) begin
			next_q <= step_next;
		end
		if (cmd.cache_load) begin
			cache_left_q  <= rd_left_q;
			cache_right_q <= rd_right_q;
		end else if (cmd.res == RES_DEC_EVAL && !rd_leaf) begin
			cache_left_q  <= rd_left_q;
			cache_right_q <= rd_right_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		unique case (cmd.res)
			RES_NONE: begin
				out_q <= out_q;
			end
			RES_DEC_MISS, RES_INS_FULL: begin
				out_q.symbol_out   <= '0;
				out_q.symbol_valid <= 1'b0;
				out_q.error_flag   <= 1'b1;
			end
			RES_DEC_EVAL: begin
				out_q.symbol_out   <= rd_leaf ? rd_sym_q : '0;
				out_q.symbol_valid <= rd_leaf;
				out_q.error_flag   <= 1'b0;
			end
			RES_INS_OK: begin
				out_q.symbol_out   <= '0;
				out_q.symbol_valid <= 1'b0;
				out_q.error_flag   <= 1'b0;
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	// Walk control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_left_q  <= '0;
			root_right_q <= '0;
			cur_q        <= '0;
			cache_ok_q   <= 1'b0;
			remain_q     <= '0;
			node_q       <= '0;
			fresh_q      <= 1'b0;
			count_q      <= CNT_W'(1);
		end else begin
			// Start an insert walk at the root
			if (cmd.accept) begin
				remain_q <= LEN_W'(len_clip);
				node_q   <= '0;
				fresh_q  <= 1'b0;
			end
			// Descend into an existing child
			if (cmd.ins_step && !ins_done && ins_desc) begin
				node_q   <= ins_slot;
				remain_q <= remain_q - LEN_W'(1);
			end
			// Allocate the next node and link it
			if (alloc) begin
				node_q   <= fresh_idx;
				fresh_q  <= 1'b1;
				remain_q <= remain_q - LEN_W'(1);
				count_q  <= count_q + CNT_W'(1);
				if (node_root) begin
					root_left_q  <= new_left;
					root_right_q <= new_right;
				end
			end
			if (cmd.cache_load) begin
				cache_ok_q <= 1'b1;
			end
			// Move or reset the decode walk as the item closes
			unique case (cmd.res)
				RES_NONE: begin
					cur_q <= cur_q;
				end
				RES_DEC_MISS: begin
					cur_q <= '0;
				end
				RES_DEC_EVAL: begin
					if (rd_leaf) begin
						cur_q <= '0;
					end else begin
						cur_q      <= next_q;
						cache_ok_q <= 1'b1;
					end
				end
				RES_INS_OK: begin
					cache_ok_q <= 1'b0;
				end
				RES_INS_FULL: begin
					cur_q      <= '0;
					cache_ok_q <= 1'b0;
				end
				default: begin
					cur_q <= cur_q;
				end
			endcase
		end
	end

	// Status to the controller
	assign stat.cur_known = cur_root || cache_ok_q;
	assign stat.step_miss = (step_next == '0);
	assign stat.ins_done  = ins_done;
	assign stat.ins_desc  = ins_desc;
	assign stat.ins_full  = ins_full;

	assign rsp = out_q;

endmodule

### src/huffman_tree_bit_decoder.sv
// Code tree bit decoder. Each item gives one result. An insert item walks its
// code from the root, MSB first, and allocates missing nodes in order; every
// existing node passed below the root costs a registered read of the node
// table. A decode item closes with an error when its bit selects a missing
// child, else it reads the child to see whether it is a leaf; the first decode
// bit after an insert, while the walk stands below the root, first reloads the
// current node from the table. The result sits in an output register and a new
// item is taken while the previous result is being taken. The tables need no
// clearing pass after reset: the root is kept in flops and every other node is
// written by the insert that allocates it. Depends on htbd_pkg, htbd_ctrl and
// htbd_dpath.

module huffman_tree_bit_decoder #(
	parameter int NODE_COUNT   = htbd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = htbd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  htbd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output htbd_pkg::rsp_t rsp
);
	import htbd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	htbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	htbd_dpath #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

	// A result is only written into a free or draining output slot
	a_res_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res != RES_NONE) |-> (!rsp_valid || !rsp_stall))
		else $error("result written over a pending item");

	// A decoded symbol never comes with an error
	a_sym_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.symbol_valid && rsp.error_flag))
		else $error("symbol and error flagged together");

	// No symbol value without a valid symbol
	a_sym_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.symbol_valid) |-> (rsp.symbol_out == '0))
		else $error("symbol value without symbol_valid");

	// Only one item is in flight: no new accept while a walk runs
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins_step || cmd.cache_load) |-> req_stall)
		else $error("item accepted during a walk");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for huffman_tree_bit_decoder: inserts codes and decodes bit streams,
// predicts each result with its own code tree and checks it. Depends on htbd_pkg.

module tb;
	import htbd_pkg::*;

	localparam int NODES       = NODE_COUNT_DEF;
	localparam int CODE_CLIP   = MAX_CODE_LEN_DEF;
	localparam int CYCLE_LIMIT = 400000;

	// Code tree predictor and the queue of results it expects
	class code_tree_model;
		int               left_kid [NODES];
		int               right_kid [NODES];
		logic [SYM_W-1:0] leaf_sym [NODES];
		int               nodes_used = 1;
		int               walk_node = 0;
		rsp_t             pending_rsp [$];
		int               errors = 0;
		int               n_checked = 0;
		int               n_symbols = 0;
		int               n_misses = 0;
		int               n_full = 0;

		function new();
			foreach (left_kid[i]) begin
				left_kid[i]  = 0;
				right_kid[i] = 0;
				leaf_sym[i]  = '0;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// Walk the code MSB first, allocating missing nodes; 0 when the table runs out
		function bit add_code(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] word, int len);
			int   node;
			int   pos;
			int   nxt;
			logic b;
			node = 0;
			if (len > CODE_CLIP)
				len = CODE_CLIP;
			for (int i = 0; i < len; i++) begin
				pos = len - 1 - i;
				b   = (pos < CODE_W) ? word[pos] : 1'b0;
				nxt = b ? right_kid[node] : left_kid[node];
				if (nxt == 0) begin
					if (nodes_used >= NODES)
						return 1'b0;
					nxt = nodes_used;
					nodes_used++;
					left_kid[nxt]  = 0;
					right_kid[nxt] = 0;
					leaf_sym[nxt]  = sym;
					if (b)
						right_kid[node] = nxt;
					else
						left_kid[node] = nxt;
				end
				node = nxt;
			end
			return 1'b1;
		endfunction

		// Advance the tree for one accepted item and queue its result
		function void apply_request(req_t r);
			rsp_t want;
			int   nxt;
			want = '0;
			if (r.req_type == REQ_INSERT) begin
				if (!add_code(r.symbol_in, r.code_word, int'(r.code_length))) begin
					want.error_flag = 1'b1;
					walk_node = 0;
					n_full++;
				end
			end else begin
				nxt = r.code_bit ? right_kid[walk_node] : left_kid[walk_node];
				if (nxt == 0 || nxt >= NODES) begin
					want.error_flag = 1'b1;
					walk_node = 0;
					n_misses++;
				end else if (left_kid[nxt] == 0 && right_kid[nxt] == 0) begin
					want.symbol_out   = leaf_sym[nxt];
					want.symbol_valid = 1'b1;
					walk_node = 0;
					n_symbols++;
				end else begin
					walk_node = nxt;
				end
			end
			pending_rsp = {pending_rsp, want};
		endfunction

		// Compare one accepted result with the oldest expectation
		task check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				report($sformatf("result %0h arrived with no item pending", got));
				return;
			end
			want = pending_rsp.pop_front();
			n_checked++;
			if (got.symbol_out !== want.symbol_out)
				report($sformatf("result %0d symbol_out %0h, expected %0h",
					n_checked, got.symbol_out, want.symbol_out));
			if (got.symbol_valid !== want.symbol_valid)
				report($sformatf("result %0d symbol_valid %0b, expected %0b",
					n_checked, got.symbol_valid, want.symbol_valid));
			if (got.error_flag !== want.error_flag)
				report($sformatf("result %0d error_flag %0b, expected %0b",
					n_checked, got.error_flag, want.error_flag));
		endtask

		task finish_check();
			if (pending_rsp.size() != 0)
				report($sformatf("%0d results never arrived", pending_rsp.size()));
		endtask
	endclass

	typedef struct {
		logic [CODE_W-1:0] word;
		int                len;
	} code_ent_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	req_t           req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	rsp_t           rsp;

	code_tree_model tree_pred;
	code_ent_t      known_codes [$];
	int             cycles = 0;
	int             n_sent = 0;
	int             stall_left = 0;
	bit             idle_on = 1'b0;

	huffman_tree_bit_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 11);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Check accepted results and watch the cycle budget
	always @(posedge clk) begin
		cycles++;
		if (arst_n && rsp_valid && !rsp_stall)
			tree_pred.check_response(rsp);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, tree_pred.pending_rsp.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic req_t mk_insert(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] word,
			int len);
		req_t r;
		r.req_type    = REQ_INSERT;
		r.symbol_in   = sym;
		r.code_word   = word;
		r.code_length = CODE_LEN_W'(len);
		r.code_bit    = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic req_t mk_decode(logic b);
		req_t r;
		r.req_type    = REQ_DECODE;
		r.symbol_in   = SYM_W'($urandom);
		r.code_word   = $urandom;
		r.code_length = CODE_LEN_W'($urandom);
		r.code_bit    = b;
		return r;
	endfunction

	// Present one item, optionally after an idle burst, and hold it until taken
	task automatic send_item(input req_t r);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		tree_pred.apply_request(r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic put_code(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] word, int len);
		code_ent_t c;
		send_item(mk_insert(sym, word, len));
		c.word = word;
		c.len  = (len > CODE_CLIP) ? CODE_CLIP : len;
		if (c.len > 0)
			known_codes = {known_codes, c};
	endtask

	// Feed the first nbits of a code as decode bits, MSB first
	task automatic feed_code(code_ent_t c, int nbits);
		for (int i = c.len - 1; i >= c.len - nbits; i--)
			send_item(mk_decode(c.word[i]));
	endtask

	// Hold the sender until every expected result has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (tree_pred.pending_rsp.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly whole known codes, plus inserts, truncated codes and loose bits
	task automatic run_mixed(int upto);
		int        pick;
		int        len;
		code_ent_t c;
		while (n_sent < upto) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				len = $urandom_range(0, 99);
				if (len < 5)
					len = 0;
				else if (len < 80)
					len = $urandom_range(1, 8);
				else if (len < 93)
					len = $urandom_range(9, CODE_CLIP);
				else
					len = $urandom_range(CODE_CLIP + 1, 63);
				put_code(SYM_W'($urandom), $urandom, len);
			end else if (pick < 80) begin
				c = known_codes[$urandom_range(0, known_codes.size() - 1)];
				feed_code(c, c.len);
			end else if (pick < 90) begin
				c = known_codes[$urandom_range(0, known_codes.size() - 1)];
				feed_code(c, $urandom_range(1, c.len));
			end else begin
				send_item(mk_decode(1'($urandom_range(0, 1))));
			end
		end
	endtask

	initial begin
		tree_pred = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		idle_on = 1'b1;

		// Empty tree: both directions miss
		send_item(mk_decode(1'b0));
		send_item(mk_decode(1'b1));
		// Zero length changes nothing; then a complete three-symbol code
		put_code(8'h5A, 32'hFFFF_FFFF, 0);
		put_code(8'hFF, 32'h0000_0000, 1);
		put_code(8'h00, 32'h0000_0002, 2);
		put_code(8'hA5, 32'h0000_0003, 2);
		// Duplicate code keeps the first symbol; upper word bits are ignored
		put_code(8'h33, 32'hFFFF_FFFE, 2);
		send_item(mk_decode(1'b0));
		send_item(mk_decode(1'b1));
		send_item(mk_decode(1'b0));
		// Insert while the walk stands below the root, then finish the walk
		send_item(mk_decode(1'b1));
		put_code(8'h7E, 32'h0000_0001, 3);
		send_item(mk_decode(1'b1));
		// Leaf turned inner node, then a missing child halfway down
		send_item(mk_decode(1'b0));
		send_item(mk_decode(1'b0));
		send_item(mk_decode(1'b1));
		send_item(mk_decode(1'b0));
		send_item(mk_decode(1'b1));
		// Lengths past the limit are clipped
		put_code(8'hC3, 32'h8000_0001, 63);
		put_code(8'h3C, 32'hFFFF_FFFF, CODE_CLIP + 1);
		send_item(mk_decode(1'b1));
		send_item(mk_decode(1'b1));
		send_item(mk_decode(1'b0));

		run_mixed(200);
		drain_results();

		// Stretch with no idling
		idle_on = 1'b0;
		run_mixed(260);

		// Fill the node table, then hit it full with the walk below the root
		idle_on = 1'b1;
		while (tree_pred.nodes_used < NODES)
			put_code(SYM_W'($urandom), $urandom, CODE_CLIP);
		put_code(SYM_W'($urandom), $urandom, CODE_CLIP);
		send_item(mk_decode(1'b1));
		put_code(SYM_W'($urandom), $urandom, CODE_CLIP);
		send_item(mk_decode(1'b0));
		drain_results();

		run_mixed(380);
		idle_on = 1'b0;
		run_mixed(450);

		drain_results();
		repeat (20) @(posedge clk);
		tree_pred.finish_check();

		$display("sent %0d items and checked %0d results: %0d symbols decoded,",
			n_sent, tree_pred.n_checked, tree_pred.n_symbols);
		$display("%0d missing-child misses, %0d table-full inserts, %0d of %0d nodes used",
			tree_pred.n_misses, tree_pred.n_full, tree_pred.nodes_used, NODES);
		if (tree_pred.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
